/* sv/nbge_pkg.sv */
// shared types, constants and commands of the n-body gravity step unit
package nbge_pkg;

  localparam int MAX_BODIES = 64;
  localparam int BODY_AW    = $clog2(MAX_BODIES);
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);
  localparam int DIV_W      = 64;
  localparam int SQRT_W     = 64;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_BAD  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_PAUSED = 2'd2,
    ST_SAT    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_BODY_COUNT = 2'd0,
    REG_TIME_STEP  = 2'd1,
    REG_GRAVITY    = 2'd2,
    REG_RUN_ENABLE = 2'd3
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_LOAD,
    OP_READ,
    OP_REPORT,
    OP_CLR_SAT,
    OP_LATCH_I,
    OP_LATCH_J,
    OP_DIFF,
    OP_MUL_SQ,
    OP_ADD_R2,
    OP_MUL_GM,
    OP_MUL_K,
    OP_DIV_Q,
    OP_SAT_S,
    OP_MUL_PULL,
    OP_DIV_PULL,
    OP_ACC,
    OP_WR_NV,
    OP_LATCH_MV,
    OP_MUL_MV,
    OP_MOVE,
    OP_WR_BODY
  } dp_op_e;

  typedef logic [2:0][31:0] vec3_t;

  typedef struct packed {
    dp_op_e               op;
    logic [BODY_AW-1:0]   addr;
    logic [1:0]           ax;
    status_e              status;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sq_busy;
    logic r2_zero;
    logic sat;
  } dp_stat_t;

endpackage

/* sv/nbge_div.sv */
// serial restoring divider, one quotient bit per cycle
module nbge_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [nbge_pkg::DIV_W-1:0] num_i,
  input  logic [nbge_pkg::DIV_W-1:0] den_i,
  output logic                       busy_o,
  output logic [nbge_pkg::DIV_W-1:0] quo_o
);
  import nbge_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [DIV_W-1:0] rem_q, quo_q, den_q;
  logic [DIV_W:0]   sh;
  logic             ge;
  logic [DIV_W:0]   diff;

  assign sh   = {rem_q, quo_q[DIV_W-1]};
  assign ge   = sh >= {1'b0, den_q};
  assign diff = sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '1;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

/* sv/nbge_isqrt.sv */
// serial integer square root, one root bit per cycle
module nbge_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [nbge_pkg::SQRT_W-1:0]   rad_i,
  output logic                          busy_o,
  output logic [nbge_pkg::SQRT_W/2-1:0] root_o
);
  import nbge_pkg::*;

  localparam int RW = SQRT_W / 2;
  localparam int CW = $clog2(RW);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [SQRT_W-1:0] rad_q;
  logic [RW+1:0]     rem_q;
  logic [RW-1:0]     root_q;
  logic [RW+3:0]     sh, trial, diff;
  logic              ge;

  assign sh    = {rem_q, rad_q[SQRT_W-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign ge    = sh >= trial;
  assign diff  = sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '1;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[SQRT_W-3:0], 2'b00};
      rem_q  <= ge ? diff[RW+1:0] : sh[RW+1:0];
      root_q <= {root_q[RW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

/* sv/nbge_dp.sv */
// datapath: body memories, shared multiplier, divider and square root
module nbge_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nbge_pkg::dp_cmd_t cmd_i,
  output nbge_pkg::dp_stat_t stat_o,
  input  logic [5:0]        body_index_i,
  input  logic [31:0]       pos_x_i,
  input  logic [31:0]       pos_y_i,
  input  logic [31:0]       pos_z_i,
  input  logic [31:0]       vel_x_i,
  input  logic [31:0]       vel_y_i,
  input  logic [31:0]       vel_z_i,
  input  logic [31:0]       body_mass_i,
  input  logic [31:0]       time_step_i,
  input  logic [31:0]       gravity_i,
  output logic [5:0]        out_index_o,
  output logic [31:0]       out_pos_x_o,
  output logic [31:0]       out_pos_y_o,
  output logic [31:0]       out_pos_z_o,
  output logic [31:0]       out_vel_x_o,
  output logic [31:0]       out_vel_y_o,
  output logic [31:0]       out_vel_z_o,
  output logic [31:0]       out_mass_o,
  output logic [1:0]        status_o
);
  import nbge_pkg::*;

  localparam logic signed [35:0] SMAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] SMIN = -36'sh0_8000_0000;
  localparam logic [33:0]        MCLAMP = 34'h2_0000_0000;

  function automatic logic [32:0] sat32(input logic signed [35:0] v);
    logic [32:0] r;
    if (v > SMAX) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < SMIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // body storage
  vec3_t       pos_mem  [MAX_BODIES];
  vec3_t       vel_mem  [MAX_BODIES];
  vec3_t       nv_mem   [MAX_BODIES];
  logic [31:0] mass_mem [MAX_BODIES];

  vec3_t       pos_rd_q, vel_rd_q, nv_rd_q;
  logic [31:0] mass_rd_q;

  // captured transaction
  logic [5:0]  idx_q;
  vec3_t       in_pos_q, in_vel_q;
  logic [31:0] in_mass_q;

  // working registers
  vec3_t       pi_q, pj_q, acc_q, ad_q;
  logic [2:0]  neg_q;
  logic [31:0] mj_q, s_q;
  logic [49:0] r2_q;
  logic [32:0] r_q;
  logic [63:0] p_q;
  logic        sat_q;

  logic [BODY_AW-1:0] ld_addr;
  assign ld_addr = BODY_AW'(idx_q);

  // memory write and read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      pos_mem[ld_addr]  <= in_pos_q;
      vel_mem[ld_addr]  <= in_vel_q;
      mass_mem[ld_addr] <= in_mass_q;
    end else if (cmd_i.op == OP_WR_BODY) begin
      pos_mem[cmd_i.addr] <= pi_q;
      vel_mem[cmd_i.addr] <= acc_q;
    end
    if (cmd_i.op == OP_WR_NV) begin
      nv_mem[cmd_i.addr] <= acc_q;
    end
    pos_rd_q  <= pos_mem[cmd_i.addr];
    vel_rd_q  <= vel_mem[cmd_i.addr];
    nv_rd_q   <= nv_mem[cmd_i.addr];
    mass_rd_q <= mass_mem[cmd_i.addr];
  end

  // per-axis differences
  vec3_t       ad_d;
  logic [2:0]  neg_d;
  always_comb begin
    logic signed [32:0] d;
    logic [32:0]        dn;
    ad_d  = '0;
    neg_d = '0;
    for (int k = 0; k < 3; k++) begin
      d        = $signed({pj_q[k][31], pj_q[k]}) - $signed({pi_q[k][31], pi_q[k]});
      dn       = -d;
      neg_d[k] = d[32];
      ad_d[k]  = d[32] ? dn[31:0] : d[31:0];
    end
  end

  // shared multiplier operand select
  logic [31:0] acc_ax, abs_acc, mul_a, mul_b;
  logic [31:0] acc_neg;
  logic        mul_en;
  assign acc_ax  = acc_q[cmd_i.ax];
  assign acc_neg = -acc_ax;
  assign abs_acc = acc_ax[31] ? acc_neg : acc_ax;

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (cmd_i.op)
      OP_MUL_SQ:   begin mul_a = ad_q[cmd_i.ax]; mul_b = ad_q[cmd_i.ax]; end
      OP_MUL_GM:   begin mul_a = gravity_i;      mul_b = mj_q;           end
      OP_MUL_K:    begin mul_a = p_q[63:32];     mul_b = time_step_i;    end
      OP_MUL_PULL: begin mul_a = s_q;            mul_b = ad_q[cmd_i.ax]; end
      OP_MUL_MV:   begin mul_a = abs_acc;        mul_b = time_step_i;    end
      default:     mul_en = 1'b0;
    endcase
  end

  // divider and square root
  logic        div_start, sq_start, div_busy, sq_busy;
  logic [63:0] div_den, quo;
  logic [31:0] root;

  assign div_start = (cmd_i.op == OP_DIV_Q) || (cmd_i.op == OP_DIV_PULL);
  assign sq_start  = (cmd_i.op == OP_DIV_Q);
  assign div_den   = (cmd_i.op == OP_DIV_Q) ? 64'(r2_q) : 64'(r_q);

  nbge_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (p_q),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  nbge_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   ({r2_q, 14'b0}),
    .busy_o  (sq_busy),
    .root_o  (root)
  );

  // velocity accumulate and position move, clamped so the 36-bit sum saturates alike
  logic [33:0]        acc_mc, mv_mc;
  logic signed [35:0] acc_sum, mv_sum;
  logic [32:0]        acc_sat, mv_sat;
  logic               s_over;

  always_comb begin
    logic signed [35:0] base_a, base_p, add_a, add_p;
    acc_mc  = (|quo[63:33]) ? MCLAMP : quo[33:0];
    mv_mc   = (|p_q[63:49]) ? MCLAMP : p_q[49:16];
    base_a  = $signed({{4{acc_ax[31]}}, acc_ax});
    base_p  = $signed({{4{pi_q[cmd_i.ax][31]}}, pi_q[cmd_i.ax]});
    add_a   = $signed({2'b00, acc_mc});
    add_p   = $signed({2'b00, mv_mc});
    acc_sum = neg_q[cmd_i.ax] ? base_a - add_a : base_a + add_a;
    mv_sum  = acc_ax[31] ? base_p - add_p : base_p + add_p;
    acc_sat = sat32(acc_sum);
    mv_sat  = sat32(mv_sum);
    s_over  = |quo[63:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        OP_CLR_SAT: sat_q <= 1'b0;
        OP_SAT_S:   sat_q <= sat_q | s_over;
        OP_ACC:     sat_q <= sat_q | acc_sat[32];
        OP_MOVE:    sat_q <= sat_q | mv_sat[32];
        default:    sat_q <= sat_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      p_q <= mul_a * mul_b;
    end
    unique case (cmd_i.op)
      OP_CAPTURE: begin
        idx_q     <= body_index_i;
        in_pos_q  <= {pos_z_i, pos_y_i, pos_x_i};
        in_vel_q  <= {vel_z_i, vel_y_i, vel_x_i};
        in_mass_q <= body_mass_i;
      end
      OP_LOAD: begin
        out_index_o <= idx_q;
        out_pos_x_o <= in_pos_q[0];
        out_pos_y_o <= in_pos_q[1];
        out_pos_z_o <= in_pos_q[2];
        out_vel_x_o <= in_vel_q[0];
        out_vel_y_o <= in_vel_q[1];
        out_vel_z_o <= in_vel_q[2];
        out_mass_o  <= in_mass_q;
        status_o    <= ST_OK;
      end
      OP_READ: begin
        out_index_o <= idx_q;
        out_pos_x_o <= pos_rd_q[0];
        out_pos_y_o <= pos_rd_q[1];
        out_pos_z_o <= pos_rd_q[2];
        out_vel_x_o <= vel_rd_q[0];
        out_vel_y_o <= vel_rd_q[1];
        out_vel_z_o <= vel_rd_q[2];
        out_mass_o  <= mass_rd_q;
        status_o    <= ST_OK;
      end
      OP_REPORT: begin
        out_index_o <= '0;
        out_pos_x_o <= '0;
        out_pos_y_o <= '0;
        out_pos_z_o <= '0;
        out_vel_x_o <= '0;
        out_vel_y_o <= '0;
        out_vel_z_o <= '0;
        out_mass_o  <= '0;
        status_o    <= cmd_i.status;
      end
      OP_LATCH_I: begin
        pi_q  <= pos_rd_q;
        acc_q <= vel_rd_q;
      end
      OP_LATCH_J: begin
        pj_q <= pos_rd_q;
        mj_q <= mass_rd_q;
      end
      OP_DIFF: begin
        ad_q  <= ad_d;
        neg_q <= neg_d;
        r2_q  <= '0;
      end
      OP_ADD_R2: r2_q <= r2_q + 50'(p_q[63:16]);
      OP_SAT_S: begin
        s_q <= s_over ? 32'hFFFF_FFFF : quo[31:0];
        r_q <= {root, 1'b0};
      end
      OP_ACC:      acc_q[cmd_i.ax] <= acc_sat[31:0];
      OP_LATCH_MV: begin
        pi_q  <= pos_rd_q;
        acc_q <= nv_rd_q;
      end
      OP_MOVE:     pi_q[cmd_i.ax] <= mv_sat[31:0];
      default: ;
    endcase
  end

  assign stat_o = '{div_busy: div_busy, sq_busy: sq_busy,
                    r2_zero: (r2_q == '0), sat: sat_q};

endmodule

/* sv/nbge_ctrl.sv */
// controller: command decode and the pair and move sequencing of a run
module nbge_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  input  logic [1:0]                  cmd_i,
  input  logic [5:0]                  body_index_i,
  input  logic [7:0]                  step_count_i,
  input  logic                        run_en_i,
  input  logic [nbge_pkg::CNT_W-1:0]  n_i,
  input  nbge_pkg::dp_stat_t          stat_i,
  output nbge_pkg::dp_cmd_t           cmd_o,
  output logic                        busy_o,
  output logic                        done_o
);
  import nbge_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_READ, S_REPORT, S_RUN_INIT, S_T_CHK,
    S_I_CHK, S_I_LAT, S_J_CHK, S_J_LAT, S_DIFF, S_SQ, S_ADD, S_ZCHK,
    S_GM, S_K, S_DSTART, S_DWAIT, S_PM, S_PDS, S_PDW, S_WR_NV,
    S_MV_RD, S_MV_LAT, S_MV_MUL, S_MV_ADD, S_MV_WR
  } state_e;

  state_e          state_q;
  logic [CNT_W-1:0] i_q, j_q;
  logic [7:0]      t_q, steps_q;
  logic [1:0]      ax_q;
  status_e         status_q;
  logic            done_q;
  logic            idx_oor;

  assign idx_oor = (32'(body_index_i) >= 32'(MAX_BODIES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      t_q      <= '0;
      steps_q  <= '0;
      ax_q     <= '0;
      status_q <= ST_OK;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            steps_q <= step_count_i;
            priority if (cmd_i == CMD_RUN) begin
              if (!run_en_i) begin
                status_q <= ST_PAUSED;
                state_q  <= S_REPORT;
              end else begin
                state_q <= S_RUN_INIT;
              end
            end else if (cmd_i == CMD_BAD || idx_oor) begin
              status_q <= ST_RANGE;
              state_q  <= S_REPORT;
            end else if (cmd_i == CMD_LOAD) begin
              state_q <= S_LOAD;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_LOAD, S_READ, S_REPORT: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_RUN_INIT: begin
          t_q     <= '0;
          state_q <= S_T_CHK;
        end
        S_T_CHK: begin
          if (t_q == steps_q) begin
            status_q <= stat_i.sat ? ST_SAT : ST_OK;
            state_q  <= S_REPORT;
          end else begin
            i_q     <= '0;
            state_q <= S_I_CHK;
          end
        end
        S_I_CHK: begin
          if (i_q == n_i) begin
            i_q     <= '0;
            state_q <= S_MV_RD;
          end else begin
            state_q <= S_I_LAT;
          end
        end
        S_I_LAT: begin
          j_q     <= '0;
          state_q <= S_J_CHK;
        end
        S_J_CHK: begin
          priority if (j_q == n_i) begin
            state_q <= S_WR_NV;
          end else if (j_q == i_q) begin
            j_q <= j_q + 1'b1;
          end else begin
            state_q <= S_J_LAT;
          end
        end
        S_J_LAT: state_q <= S_DIFF;
        S_DIFF: begin
          ax_q    <= '0;
          state_q <= S_SQ;
        end
        S_SQ: state_q <= S_ADD;
        S_ADD: begin
          if (ax_q == 2'd2) begin
            state_q <= S_ZCHK;
          end else begin
            ax_q    <= ax_q + 1'b1;
            state_q <= S_SQ;
          end
        end
        S_ZCHK: begin
          // coincident pair contributes nothing
          if (stat_i.r2_zero) begin
            j_q     <= j_q + 1'b1;
            state_q <= S_J_CHK;
          end else begin
            state_q <= S_GM;
          end
        end
        S_GM:     state_q <= S_K;
        S_K:      state_q <= S_DSTART;
        S_DSTART: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (!stat_i.div_busy && !stat_i.sq_busy) begin
            ax_q    <= '0;
            state_q <= S_PM;
          end
        end
        S_PM:  state_q <= S_PDS;
        S_PDS: state_q <= S_PDW;
        S_PDW: begin
          if (!stat_i.div_busy) begin
            if (ax_q == 2'd2) begin
              j_q     <= j_q + 1'b1;
              state_q <= S_J_CHK;
            end else begin
              ax_q    <= ax_q + 1'b1;
              state_q <= S_PM;
            end
          end
        end
        S_WR_NV: begin
          i_q     <= i_q + 1'b1;
          state_q <= S_I_CHK;
        end
        S_MV_RD: begin
          if (i_q == n_i) begin
            t_q     <= t_q + 1'b1;
            state_q <= S_T_CHK;
          end else begin
            state_q <= S_MV_LAT;
          end
        end
        S_MV_LAT: begin
          ax_q    <= '0;
          state_q <= S_MV_MUL;
        end
        S_MV_MUL: state_q <= S_MV_ADD;
        S_MV_ADD: begin
          if (ax_q == 2'd2) begin
            state_q <= S_MV_WR;
          end else begin
            ax_q    <= ax_q + 1'b1;
            state_q <= S_MV_MUL;
          end
        end
        S_MV_WR: begin
          i_q     <= i_q + 1'b1;
          state_q <= S_MV_RD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.op     = OP_NOP;
    cmd_o.addr   = i_q[BODY_AW-1:0];
    cmd_o.ax     = ax_q;
    cmd_o.status = status_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.addr = BODY_AW'(body_index_i);
        if (start) begin
          cmd_o.op = OP_CAPTURE;
        end
      end
      S_LOAD:     cmd_o.op = OP_LOAD;
      S_READ:     cmd_o.op = OP_READ;
      S_REPORT:   cmd_o.op = OP_REPORT;
      S_RUN_INIT: cmd_o.op = OP_CLR_SAT;
      S_I_LAT:    cmd_o.op = OP_LATCH_I;
      S_J_CHK:    cmd_o.addr = j_q[BODY_AW-1:0];
      S_J_LAT:    cmd_o.op = OP_LATCH_J;
      S_DIFF:     cmd_o.op = OP_DIFF;
      S_SQ:       cmd_o.op = OP_MUL_SQ;
      S_ADD:      cmd_o.op = OP_ADD_R2;
      S_GM:       cmd_o.op = OP_MUL_GM;
      S_K:        cmd_o.op = OP_MUL_K;
      S_DSTART:   cmd_o.op = OP_DIV_Q;
      S_DWAIT: begin
        if (!stat_i.div_busy && !stat_i.sq_busy) begin
          cmd_o.op = OP_SAT_S;
        end
      end
      S_PM:       cmd_o.op = OP_MUL_PULL;
      S_PDS:      cmd_o.op = OP_DIV_PULL;
      S_PDW: begin
        if (!stat_i.div_busy) begin
          cmd_o.op = OP_ACC;
        end
      end
      S_WR_NV:    cmd_o.op = OP_WR_NV;
      S_MV_LAT:   cmd_o.op = OP_LATCH_MV;
      S_MV_MUL:   cmd_o.op = OP_MUL_MV;
      S_MV_ADD:   cmd_o.op = OP_MOVE;
      S_MV_WR:    cmd_o.op = OP_WR_BODY;
      default: ;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

/* sv/nbody_gravity_euler_step_unit.sv */
// top level of the n-body gravity step unit: register file, controller and datapath
//
//   channel   direction  handshake             payload
//   command   in         start high, busy low  cmd_i, body_index_i, pos/vel/mass, step_count_i
//   result    out        out_valid_o, 1 cycle  out_index_o, out_pos/vel/mass, status_o
//   config    in         cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// each step of a run passes over all ordered pairs, and each pair uses the
// shared 64-step divider four times (acceleration term and one per axis).
// coincident pairs skip the divider. reset is asynchronous and clears control
// state and the config registers; body memories hold garbage until loaded.
// the receiver cannot stall: out_valid_o is high for exactly one cycle.
module nbody_gravity_euler_step_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [5:0]  body_index_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] vel_z_i,
  input  logic [31:0] body_mass_i,
  input  logic [7:0]  step_count_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        out_valid_o,
  output logic [5:0]  out_index_o,
  output logic [31:0] out_pos_x_o,
  output logic [31:0] out_pos_y_o,
  output logic [31:0] out_pos_z_o,
  output logic [31:0] out_vel_x_o,
  output logic [31:0] out_vel_y_o,
  output logic [31:0] out_vel_z_o,
  output logic [31:0] out_mass_o,
  output logic [1:0]  status_o
);
  import nbge_pkg::*;

  logic [6:0]  body_count_q;
  logic [31:0] time_step_q;
  logic [31:0] gravity_q;
  logic        run_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_count_q <= '0;
      time_step_q  <= 32'd655;
      gravity_q    <= 32'd1;
      run_en_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BODY_COUNT: body_count_q <= cfg_wdata_i[6:0];
        REG_TIME_STEP:  time_step_q  <= cfg_wdata_i;
        REG_GRAVITY:    gravity_q    <= cfg_wdata_i;
        REG_RUN_ENABLE: run_en_q     <= cfg_wdata_i[0];
      endcase
    end
  end

  // counts above the body capacity act as a full set
  logic [CNT_W-1:0] n_bodies;
  assign n_bodies = (32'(body_count_q) > 32'(MAX_BODIES)) ? CNT_W'(MAX_BODIES)
                                                          : CNT_W'(body_count_q);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  nbge_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .cmd_i        (cmd_i),
    .body_index_i (body_index_i),
    .step_count_i (step_count_i),
    .run_en_i     (run_en_q),
    .n_i          (n_bodies),
    .stat_i       (dp_stat),
    .cmd_o        (dp_cmd),
    .busy_o       (busy),
    .done_o       (out_valid_o)
  );

  nbge_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .body_index_i (body_index_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .vel_x_i      (vel_x_i),
    .vel_y_i      (vel_y_i),
    .vel_z_i      (vel_z_i),
    .body_mass_i  (body_mass_i),
    .time_step_i  (time_step_q),
    .gravity_i    (gravity_q),
    .out_index_o  (out_index_o),
    .out_pos_x_o  (out_pos_x_o),
    .out_pos_y_o  (out_pos_y_o),
    .out_pos_z_o  (out_pos_z_o),
    .out_vel_x_o  (out_vel_x_o),
    .out_vel_y_o  (out_vel_y_o),
    .out_vel_z_o  (out_vel_z_o),
    .out_mass_o   (out_mass_o),
    .status_o     (status_o)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not make the unit busy");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !busy)
    else $error("result strobe while still busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobe longer than one cycle");
`endif

endmodule

/* tb/nbge_checker.sv */
// checker for the n-body gravity step unit: tracks config, predicts results and compares
module nbge_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [5:0]  body_index_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] vel_z_i,
  input  logic [31:0] body_mass_i,
  input  logic [7:0]  step_count_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        out_valid_o,
  input  logic [5:0]  out_index_o,
  input  logic [31:0] out_pos_x_o,
  input  logic [31:0] out_pos_y_o,
  input  logic [31:0] out_pos_z_o,
  input  logic [31:0] out_vel_x_o,
  input  logic [31:0] out_vel_y_o,
  input  logic [31:0] out_vel_z_o,
  input  logic [31:0] out_mass_o,
  input  logic [1:0]  status_o,
  output int          err_cnt,
  output int          pending
);
  import nbge_pkg::*;

  typedef struct packed {
    logic [5:0]  index;
    logic [31:0] px, py, pz, vx, vy, vz, mass;
    status_e     status;
  } body_result_t;

  body_result_t expected_q[$];

  longint          body_px[MAX_BODIES], body_py[MAX_BODIES], body_pz[MAX_BODIES];
  longint          body_vx[MAX_BODIES], body_vy[MAX_BODIES], body_vz[MAX_BODIES];
  longint unsigned body_m[MAX_BODIES];
  longint          new_vx[MAX_BODIES], new_vy[MAX_BODIES], new_vz[MAX_BODIES];
  bit              sat_flag;
  longint unsigned n_bodies, dt, grav;
  bit              running;

  assign pending = expected_q.size();

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sh7FFFFFFF) begin
      sat_flag = 1;
      return 64'sh7FFFFFFF;
    end
    if (v < -64'sh80000000) begin
      sat_flag = 1;
      return -64'sh80000000;
    end
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint pull(longint unsigned s, longint d, longint unsigned r);
    longint unsigned m;
    m = (s * mag(d)) / r;
    return d < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint advance(longint p, longint v);
    longint m;
    m = longint'((mag(v) * dt) >> 16);
    return clamp32(v < 0 ? p - m : p + m);
  endfunction

  // one semi-implicit euler iteration over the first n bodies
  task automatic gravity_iteration(int n);
    longint          ax, ay, az, dx, dy, dz;
    longint unsigned r2, gm, k, q, s, r;
    for (int i = 0; i < n; i++) begin
      ax = body_vx[i];
      ay = body_vy[i];
      az = body_vz[i];
      for (int j = 0; j < n; j++) begin
        if (i == j) continue;
        dx = body_px[j] - body_px[i];
        dy = body_py[j] - body_py[i];
        dz = body_pz[j] - body_pz[i];
        r2 = ((mag(dx) * mag(dx)) >> 16) + ((mag(dy) * mag(dy)) >> 16)
           + ((mag(dz) * mag(dz)) >> 16);
        if (r2 == 0) continue;
        gm = (grav * body_m[j]) >> 32;
        k  = gm * dt;
        q  = k / r2;
        if (q > 64'hFFFFFFFF) begin
          sat_flag = 1;
          s = 64'hFFFFFFFF;
        end else begin
          s = q;
        end
        r  = int_sqrt(r2 << 14) << 1;
        ax = clamp32(ax + pull(s, dx, r));
        ay = clamp32(ay + pull(s, dy, r));
        az = clamp32(az + pull(s, dz, r));
      end
      new_vx[i] = ax;
      new_vy[i] = ay;
      new_vz[i] = az;
    end
    for (int i = 0; i < n; i++) begin
      body_vx[i] = new_vx[i];
      body_vy[i] = new_vy[i];
      body_vz[i] = new_vz[i];
      body_px[i] = advance(body_px[i], new_vx[i]);
      body_py[i] = advance(body_py[i], new_vy[i]);
      body_pz[i] = advance(body_pz[i], new_vz[i]);
    end
  endtask

  task automatic predict_command();
    body_result_t res;
    int           n;
    int           ix;
    res = '0;
    ix  = body_index_i;
    case (cmd_e'(cmd_i))
      CMD_RUN: begin
        if (!running) begin
          res.status = ST_PAUSED;
        end else begin
          n = n_bodies > MAX_BODIES ? MAX_BODIES : int'(n_bodies);
          sat_flag = 0;
          for (int t = 0; t < step_count_i; t++) gravity_iteration(n);
          res.status = sat_flag ? ST_SAT : ST_OK;
        end
      end
      CMD_BAD: res.status = ST_RANGE;
      default: begin
        if (cmd_e'(cmd_i) == CMD_LOAD) begin
          body_px[ix] = longint'($signed(pos_x_i));
          body_py[ix] = longint'($signed(pos_y_i));
          body_pz[ix] = longint'($signed(pos_z_i));
          body_vx[ix] = longint'($signed(vel_x_i));
          body_vy[ix] = longint'($signed(vel_y_i));
          body_vz[ix] = longint'($signed(vel_z_i));
          body_m[ix]  = body_mass_i;
        end
        res.index  = 6'(ix);
        res.px     = body_px[ix][31:0];
        res.py     = body_py[ix][31:0];
        res.pz     = body_pz[ix][31:0];
        res.vx     = body_vx[ix][31:0];
        res.vy     = body_vy[ix][31:0];
        res.vz     = body_vz[ix][31:0];
        res.mass   = body_m[ix][31:0];
        res.status = ST_OK;
      end
    endcase
    expected_q = {expected_q, res};
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    err_cnt++;
  endtask

  initial begin
    for (int i = 0; i < MAX_BODIES; i++) begin
      body_px[i] = 0; body_py[i] = 0; body_pz[i] = 0;
      body_vx[i] = 0; body_vy[i] = 0; body_vz[i] = 0;
      body_m[i]  = 0;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_cnt  = 0;
      n_bodies = 0;
      dt       = 655;
      grav     = 1;
      running  = 0;
      sat_flag = 0;
    end else begin
      body_result_t want;
      if (out_valid_o) begin
        if (expected_q.size() == 0) begin
          $display("mismatch at %0t: result with no transaction outstanding", $time);
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (out_index_o != want.index) report("index", out_index_o, want.index);
          if (out_pos_x_o != want.px)    report("pos_x", out_pos_x_o, want.px);
          if (out_pos_y_o != want.py)    report("pos_y", out_pos_y_o, want.py);
          if (out_pos_z_o != want.pz)    report("pos_z", out_pos_z_o, want.pz);
          if (out_vel_x_o != want.vx)    report("vel_x", out_vel_x_o, want.vx);
          if (out_vel_y_o != want.vy)    report("vel_y", out_vel_y_o, want.vy);
          if (out_vel_z_o != want.vz)    report("vel_z", out_vel_z_o, want.vz);
          if (out_mass_o != want.mass)   report("mass", out_mass_o, want.mass);
          if (status_o != want.status)   report("status", status_o, want.status);
        end
      end
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_BODY_COUNT: n_bodies = cfg_wdata_i[6:0];
          REG_TIME_STEP:  dt       = cfg_wdata_i;
          REG_GRAVITY:    grav     = cfg_wdata_i;
          REG_RUN_ENABLE: running  = cfg_wdata_i[0];
        endcase
      end
      if (start && !busy) predict_command();
    end
  end

endmodule

/* tb/tb_top.sv */
// testbench top of the n-body gravity step unit: stimulus, watchdog and verdict
module tb_top;
  import nbge_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000000;

  typedef struct {
    cmd_e        c;
    logic [5:0]  ix;
    logic [31:0] p[3];
    logic [31:0] v[3];
    logic [31:0] m;
    logic [7:0]  n;
  } body_cmd_t;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  cmd_i = '0;
  logic [5:0]  body_index_i = '0;
  logic [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [31:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic [31:0] body_mass_i = '0;
  logic [7:0]  step_count_i = '0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        out_valid_o;
  logic [5:0]  out_index_o;
  logic [31:0] out_pos_x_o, out_pos_y_o, out_pos_z_o;
  logic [31:0] out_vel_x_o, out_vel_y_o, out_vel_z_o;
  logic [31:0] out_mass_o;
  logic [1:0]  status_o;
  int          err_cnt;
  int          pending;
  int          idle_pct;
  int          stall_cnt;
  bit          loaded[MAX_BODIES];

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  nbody_gravity_euler_step_unit i_dut (.*);

  nbge_checker i_checker (.*);

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || out_valid_o) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(2))
      0: return $urandom();
      1: return $unsigned($signed($urandom_range(16)) - 8) << 16 | $urandom_range(16'hFFFF);
      default: begin
        case ($urandom_range(3))
          0: return 32'h0;
          1: return 32'h7FFFFFFF;
          2: return 32'h80000000;
          default: return 32'hFFFFFFFF;
        endcase
      end
    endcase
  endfunction

  function automatic body_cmd_t make_load(logic [5:0] ix);
    body_cmd_t it;
    it.c  = CMD_LOAD;
    it.ix = ix;
    for (int a = 0; a < 3; a++) begin
      it.p[a] = pick_value();
      it.v[a] = pick_value();
    end
    it.m = pick_value();
    it.n = 8'($urandom());
    return it;
  endfunction

  function automatic body_cmd_t make_cmd(cmd_e c, logic [5:0] ix, logic [7:0] n);
    body_cmd_t it;
    it   = make_load(ix);
    it.c = c;
    it.n = n;
    return it;
  endfunction

  // drive one command and hold it until the unit takes it
  task automatic issue(body_cmd_t it);
    start        <= 1;
    cmd_i        <= it.c;
    body_index_i <= it.ix;
    pos_x_i      <= it.p[0];
    pos_y_i      <= it.p[1];
    pos_z_i      <= it.p[2];
    vel_x_i      <= it.v[0];
    vel_y_i      <= it.v[1];
    vel_z_i      <= it.v[2];
    body_mass_i  <= it.m;
    step_count_i <= it.n;
    if (it.c == CMD_LOAD) loaded[it.ix] = 1;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e r, logic [31:0] val);
    cfg_we_i    <= 1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 0;
    @(posedge clk_i);
  endtask

  // two bodies a given offset apart, used for close and coincident pairs
  task automatic load_pair(logic [31:0] offset, logic [31:0] mass);
    body_cmd_t it;
    it = make_load(0);
    it.p = '{32'h0001_0000, 32'hFFFF_0000, 32'h0};
    it.v = '{32'h0, 32'h0, 32'h0};
    it.m = mass;
    issue(it);
    it.ix   = 1;
    it.p[0] = it.p[0] + offset;
    issue(it);
  endtask

  task automatic random_phase(int items);
    body_cmd_t it;
    int        sel;
    for (int k = 0; k < items; k++) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        it = make_load(6'($urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(7)));
      end else if (sel < 70) begin
        do it = make_cmd(CMD_READ, 6'($urandom_range(63)), 8'd0); while (!loaded[it.ix]);
      end else if (sel < 92) begin
        it = make_cmd(CMD_RUN, 6'd0,
                      8'($urandom_range(9) == 0 ? 0 : $urandom_range(1, 3)));
      end else begin
        it = make_cmd(CMD_BAD, 6'($urandom_range(63)), 8'($urandom()));
      end
      issue(it);
    end
    drain();
  endtask

  task automatic random_config(int max_n);
    write_reg(REG_BODY_COUNT, $urandom_range(max_n));
    write_reg(REG_TIME_STEP, $urandom_range(1) ? $urandom() : $urandom_range(32'h2_0000));
    write_reg(REG_GRAVITY, $urandom_range(1) ? $urandom() : $urandom_range(32'hFFFF));
    write_reg(REG_RUN_ENABLE, 32'($urandom_range(4) != 0));
  endtask

  initial begin
    idle_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // paused run and unknown command straight out of reset, then loads and reads
    issue(make_cmd(CMD_RUN, 0, 1));
    issue(make_cmd(CMD_BAD, 6'h3F, 8'hFF));
    for (int s = 0; s < 8; s++) issue(make_load(6'(s)));
    issue(make_load(6'h3F));
    issue(make_cmd(CMD_READ, 6'h3F, 0));
    issue(make_cmd(CMD_READ, 0, 0));
    drain();

    // empty body set runs without effect
    write_reg(REG_BODY_COUNT, 0);
    write_reg(REG_RUN_ENABLE, 1);
    issue(make_cmd(CMD_RUN, 0, 8'd3));
    drain();

    // coincident pair, zero steps, then a close heavy pair that saturates
    write_reg(REG_BODY_COUNT, 2);
    write_reg(REG_TIME_STEP, 32'hFFFFFFFF);
    write_reg(REG_GRAVITY, 32'hFFFFFFFF);
    load_pair(32'h0, 32'hFFFFFFFF);
    issue(make_cmd(CMD_RUN, 0, 8'd0));
    issue(make_cmd(CMD_RUN, 0, 8'd1));
    load_pair(32'h0000_0100, 32'hFFFFFFFF);
    issue(make_cmd(CMD_RUN, 0, 8'd1));
    issue(make_cmd(CMD_READ, 0, 0));
    issue(make_cmd(CMD_READ, 1, 0));
    drain();

    // longest run on a light pair with zero dt and zero gravity
    write_reg(REG_TIME_STEP, 32'h0);
    write_reg(REG_GRAVITY, 32'h0);
    load_pair(32'h0004_0000, 32'h0001_0000);
    issue(make_cmd(CMD_RUN, 0, 8'hFF));
    issue(make_cmd(CMD_READ, 1, 0));
    drain();

    // oversized body count only while paused
    write_reg(REG_BODY_COUNT, 7'h7F);
    write_reg(REG_RUN_ENABLE, 0);
    issue(make_cmd(CMD_RUN, 0, 8'd5));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 57;
        2: idle_pct = 0;
        default: idle_pct = 10;
      endcase
      random_config(6);
      random_phase(15);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
